@@ rtl/byte_range_header_parser_macros.svh @@
// Assertion macros for the byte range header parser.
// Included by byte_range_header_parser, the RTL module that carries concurrent checks; needs clk and arst_n in scope.
`ifndef BYTE_RANGE_HEADER_PARSER_MACROS_SVH
`define BYTE_RANGE_HEADER_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define BRHP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked outside reset
`define BRHP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRHP_ASSERT_NOW(label, ante, cons, msg)
`define BRHP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/brhp_pkg.sv @@
// Package for the byte range header parser: widths, character codes, parse phases.
// No dependencies; imported by byte_range_header_parser.
package brhp_pkg;

	// width of the decimal accumulators including the sign position
	localparam int VALUE_BITS = 64;
	// accumulators never exceed 2^(VALUE_BITS-1)-1
	localparam int ACC_W = VALUE_BITS - 1;
	// room for acc*10 + digit
	localparam int EXT_W = ACC_W + 4;

	localparam int CHAR_W  = 8;
	localparam int START_W = 63;
	localparam int OFFS_W  = 64;

	localparam int KW_LEN = 5;
	localparam int KW_W   = 3;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_B     = 8'h62;

	// "bytes"
	localparam logic [CHAR_W-1:0] KEYWORD [KW_LEN] = '{8'h62, 8'h79, 8'h74, 8'h65, 8'h73};

	typedef enum logic [3:0] {
		PH_NONE,
		PH_SEP,
		PH_START,
		PH_DASH,
		PH_ENDNUM,
		PH_ENDSTAR,
		PH_SLASH,
		PH_LENNUM,
		PH_LENSTAR,
		PH_DEAD
	} phase_t;

endpackage

@@ rtl/byte_range_header_parser.sv @@
// Byte range header parser top level: input register, parse state, result register.
// Depends on brhp_pkg and byte_range_header_parser_macros.svh.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one header character per
//   request, text_char, with is_last marking the final character of a text.
//   The output channel (out_valid / out_stall) carries one result per text:
//   range_bad, start_offset, end_offset, total_length. Characters other than
//   the last produce no result.
//   An accepted last character passes through the input register and then
//   the result register, whose write waits while a stalled result is held.
//   Throughput: one character per cycle while the input is not stalled; each
//   character's step is set by the multiply-by-ten accumulate of one 63-bit number.
//   When the receiver stalls, the result register holds; further characters
//   keep flowing until a second last character reaches the input register,
//   which then stalls the input until the result is taken.
//   Reset (arst_n low) empties both registers and clears the parse state,
//   the same state the block returns to after every last character.
`include "byte_range_header_parser_macros.svh"

module byte_range_header_parser (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [brhp_pkg::CHAR_W-1:0]          text_char,
	input  logic                                 is_last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 range_bad,
	output logic [brhp_pkg::START_W-1:0]         start_offset,
	output logic signed [brhp_pkg::OFFS_W-1:0]   end_offset,
	output logic signed [brhp_pkg::OFFS_W-1:0]   total_length
);
	import brhp_pkg::*;

	localparam logic [ACC_W-1:0] VMAX = '1;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] text_char_s1;
	logic              is_last_s1;

	// parse state
	phase_t            phase_q, phase_d;
	logic [KW_W-1:0]   kw_q, kw_d;
	logic              kw_hit;
	logic [ACC_W-1:0]  start_q, end_q, len_q;
	logic [ACC_W-1:0]  start_d, end_d, len_d;
	logic              end_star_q, len_star_q, end_star_d, len_star_d;

	// result register
	logic                     out_valid_q;
	logic                     range_bad_q;
	logic [START_W-1:0]       start_offset_q;
	logic signed [OFFS_W-1:0] end_offset_q;
	logic signed [OFFS_W-1:0] total_length_q;

	logic                     res_bad;
	logic [START_W-1:0]       res_start;
	logic signed [OFFS_W-1:0] res_end;
	logic signed [OFFS_W-1:0] res_len;

	logic             is_digit;
	logic [3:0]       digit;
	logic [ACC_W-1:0] acc_sel, acc_next;
	logic [EXT_W-1:0] acc_ext;
	logic             out_free, process_s1, in_take;

	assign out_free   = !out_valid_q || !out_stall;
	assign process_s1 = valid_s1 && (!is_last_s1 || out_free);
	assign in_stall   = valid_s1 && !process_s1;
	assign in_take    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (process_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			text_char_s1 <= text_char;
			is_last_s1   <= is_last;
		end
	end

	assign is_digit = (text_char_s1 >= CH_ZERO) && (text_char_s1 <= CH_NINE);
	assign digit    = is_digit ? 4'(text_char_s1 - CH_ZERO) : 4'd0;

	// next phase and keyword progress
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_NONE: begin
				phase_d = PH_NONE;
			end
			PH_SEP: begin
				if (text_char_s1 == CH_SPACE || text_char_s1 == CH_EQ) phase_d = PH_SEP;
				else if (is_digit) phase_d = PH_START;
				else phase_d = PH_DEAD;
			end
			PH_START: begin
				if (is_digit) phase_d = PH_START;
				else if (text_char_s1 == CH_DASH) phase_d = PH_DASH;
				else phase_d = PH_DEAD;
			end
			PH_DASH: begin
				if (is_digit) phase_d = PH_ENDNUM;
				else if (text_char_s1 == CH_STAR) phase_d = PH_ENDSTAR;
				else phase_d = PH_DEAD;
			end
			PH_ENDNUM: begin
				if (is_digit) phase_d = PH_ENDNUM;
				else if (text_char_s1 == CH_SLASH) phase_d = PH_SLASH;
				else phase_d = PH_DEAD;
			end
			PH_ENDSTAR: begin
				phase_d = (text_char_s1 == CH_SLASH) ? PH_SLASH : PH_DEAD;
			end
			PH_SLASH: begin
				if (is_digit) phase_d = PH_LENNUM;
				else if (text_char_s1 == CH_STAR) phase_d = PH_LENSTAR;
				else phase_d = PH_DEAD;
			end
			PH_LENNUM: begin
				phase_d = is_digit ? PH_LENNUM : PH_DEAD;
			end
			default: begin
				phase_d = PH_DEAD;
			end
		endcase

		kw_hit = 1'b0;
		if (kw_q < KW_W'(KW_LEN) && text_char_s1 == KEYWORD[kw_q]) begin
			if (kw_q == KW_W'(KW_LEN - 1)) begin
				kw_hit = 1'b1;
				kw_d   = '0;
			end else begin
				kw_d = kw_q + 1'b1;
			end
		end else begin
			kw_d = (text_char_s1 == CH_B) ? KW_W'(1) : '0;
		end

		// a completed keyword restarts the tail
		if (kw_hit) phase_d = PH_SEP;
	end

	// accumulators and result fields
	always_comb begin
		case (phase_q)
			PH_DASH, PH_ENDNUM: acc_sel = end_q;
			PH_SLASH, PH_LENNUM: acc_sel = len_q;
			default: acc_sel = start_q;
		endcase

		// acc*10 + digit, saturate above VMAX
		acc_ext = (EXT_W'(acc_sel) << 3) + (EXT_W'(acc_sel) << 1) + EXT_W'(digit);
		acc_next = (acc_ext > EXT_W'(VMAX)) ? VMAX : acc_ext[ACC_W-1:0];

		start_d    = start_q;
		end_d      = end_q;
		len_d      = len_q;
		end_star_d = end_star_q;
		len_star_d = len_star_q;
		case (phase_q)
			PH_SEP, PH_START: begin
				if (is_digit) start_d = acc_next;
			end
			PH_DASH: begin
				if (is_digit) end_d = acc_next;
				else if (text_char_s1 == CH_STAR) end_star_d = 1'b1;
			end
			PH_ENDNUM: begin
				if (is_digit) end_d = acc_next;
			end
			PH_SLASH: begin
				if (is_digit) len_d = acc_next;
				else if (text_char_s1 == CH_STAR) len_star_d = 1'b1;
			end
			PH_LENNUM: begin
				if (is_digit) len_d = acc_next;
			end
			default: begin
			end
		endcase

		if (kw_hit) begin
			start_d    = '0;
			end_d      = '0;
			len_d      = '0;
			end_star_d = 1'b0;
			len_star_d = 1'b0;
		end

		res_bad   = 1'b1;
		res_start = '0;
		res_end   = '0;
		res_len   = '0;
		case (phase_d)
			PH_DASH: begin
				res_bad   = 1'b0;
				res_start = START_W'(start_d);
				res_end   = '1;
				res_len   = '1;
			end
			PH_LENNUM, PH_LENSTAR: begin
				res_bad   = 1'b0;
				res_start = START_W'(start_d);
				res_end   = end_star_d ? '1 : $signed(OFFS_W'(end_d));
				res_len   = len_star_d ? '1 : $signed(OFFS_W'(len_d));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_NONE;
			kw_q       <= '0;
			start_q    <= '0;
			end_q      <= '0;
			len_q      <= '0;
			end_star_q <= 1'b0;
			len_star_q <= 1'b0;
		end else if (process_s1) begin
			if (is_last_s1) begin
				// text done: back to the reset state
				phase_q    <= PH_NONE;
				kw_q       <= '0;
				start_q    <= '0;
				end_q      <= '0;
				len_q      <= '0;
				end_star_q <= 1'b0;
				len_star_q <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				kw_q       <= kw_d;
				start_q    <= start_d;
				end_q      <= end_d;
				len_q      <= len_d;
				end_star_q <= end_star_d;
				len_star_q <= len_star_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process_s1 && is_last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process_s1 && is_last_s1) begin
			range_bad_q    <= res_bad;
			start_offset_q <= res_start;
			end_offset_q   <= res_end;
			total_length_q <= res_len;
		end
	end

	assign out_valid    = out_valid_q;
	assign range_bad    = range_bad_q;
	assign start_offset = start_offset_q;
	assign end_offset   = end_offset_q;
	assign total_length = total_length_q;

	`BRHP_ASSERT_NOW(a_stall_only_on_blocked_last, in_stall,
		valid_s1 && is_last_s1 && out_valid_q && out_stall,
		"input stalled without a blocked last request")
	`BRHP_ASSERT_NOW(a_bad_result_zero, out_valid_q && range_bad_q,
		start_offset_q == '0 && end_offset_q == '0 && total_length_q == '0,
		"bad range result carries nonzero fields")
	`BRHP_ASSERT_NEXT(a_reset_after_last, process_s1 && is_last_s1,
		phase_q == PH_NONE && kw_q == '0 && !end_star_q && !len_star_q,
		"parse state not cleared after last character")
	`BRHP_ASSERT_NOW(a_result_source, $rose(out_valid_q),
		$past(process_s1 && is_last_s1),
		"result appeared without a last character")

endmodule
